// ===== hdl/sfs_pkg.sv =====
package sfs_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_PAUSE     = 3'd3,
    CMD_WRITE_DUR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_PLAYING = 2'd1,
    ST_WAITING = 2'd2,
    ST_DEAD    = 2'd3
  } run_state_t;

  typedef enum logic [2:0] {
    MODE_PASS     = 3'd0,
    MODE_PASS_DIE = 3'd1,
    MODE_REV      = 3'd2,
    MODE_REV_DIE  = 3'd3,
    MODE_LOOP     = 3'd4,
    MODE_REV_LOOP = 3'd5,
    MODE_PINGPONG = 3'd6
  } play_mode_t;

  localparam logic [15:0] SPEED_ONE = 16'd256;

  typedef struct packed {
    logic [5:0] frame_index;
    run_state_t anim_state;
    logic       frame_advanced;
  } result_t;

  typedef struct packed {
    logic        wr_en;
    logic [5:0]  wr_slot;
    logic [23:0] wr_data;
    logic [5:0]  rd_frame;
  } dur_req_t;

endpackage

// ===== hdl/sfs_dur_mem.sv =====
module sfs_dur_mem
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic        clk,
  input  dur_req_t    req,
  output logic [23:0] rd_data_r
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [23:0]   mem [MAX_FRAMES];
  logic [AW-1:0] mod_tbl [64];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          wr_ok;

  // frame number folded onto the table depth
  for (genvar g = 0; g < 64; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % MAX_FRAMES);
  end

  assign wr_addr = AW'(req.wr_slot);
  assign rd_addr = mod_tbl[req.rd_frame];
  assign wr_ok   = req.wr_en && ({26'd0, req.wr_slot} < 32'(MAX_FRAMES));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= req.wr_data;
    end
  end

  // write to the entry being fetched is forwarded
  always_ff @(posedge clk) begin
    if (wr_ok && (wr_addr == rd_addr)) begin
      rd_data_r <= req.wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sfs_core.sv =====
module sfs_core
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [2:0]  command,
  input  logic [19:0] elapsed_us,
  input  logic [2:0]  play_mode,
  input  logic [15:0] play_speed,
  input  logic [5:0]  frame_slot,
  input  logic [23:0] duration_us,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic [23:0] dur_rd_data,
  output dur_req_t    dur_req,
  output result_t     result
);

  typedef struct packed {
    logic [5:0] frame;
    logic       stop;
    logic       die;
    logic       bounce;
  } step_t;

  run_state_t  state_r, state_nxt;
  logic [5:0]  frame_r, frame_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic        bounce_r, bounce_nxt;
  logic [5:0]  last_r;
  logic        advanced;

  logic [35:0] prod;
  logic [36:0] sum;
  logic [31:0] acc_sat;
  logic [31:0] need;
  logic        reach;
  step_t       step;

  assign prod    = 36'(elapsed_us) * 36'(speed_r);
  assign sum     = 37'(acc_r) + 37'(prod);
  assign acc_sat = (sum[36:32] != 5'd0) ? 32'hFFFF_FFFF : sum[31:0];
  assign need    = {dur_rd_data, 8'd0};
  assign reach   = (acc_sat >= need);

  always_comb begin : frame_step
    step = '{frame: frame_r, stop: 1'b0, die: 1'b0, bounce: bounce_r};
    case (mode_r) inside
      MODE_PASS, MODE_PASS_DIE: begin
        if (last_r > frame_r) begin
          step.frame = frame_r + 6'd1;
        end else if (last_r == frame_r) begin
          if (mode_r == MODE_PASS) step.stop = 1'b1;
          else step.die = 1'b1;
        end
      end
      MODE_REV, MODE_REV_DIE: begin
        if (frame_r != 6'd0) begin
          step.frame = frame_r - 6'd1;
        end else if (mode_r == MODE_REV) begin
          step.stop = 1'b1;
        end else begin
          step.die = 1'b1;
        end
      end
      MODE_LOOP: begin
        if (last_r > frame_r) step.frame = frame_r + 6'd1;
        else if (last_r == frame_r) step.frame = 6'd0;
      end
      MODE_REV_LOOP: begin
        if (frame_r != 6'd0) step.frame = frame_r - 6'd1;
        else step.frame = last_r;
      end
      MODE_PINGPONG: begin
        // a one-frame sequence holds frame 0
        if (last_r != 6'd0) begin
          if (!bounce_r) begin
            if (last_r > frame_r) begin
              step.frame = frame_r + 6'd1;
            end else if (last_r == frame_r) begin
              step.frame  = frame_r - 6'd1;
              step.bounce = 1'b1;
            end
          end else if (frame_r != 6'd0) begin
            step.frame = frame_r - 6'd1;
          end else begin
            step.frame  = 6'd1;
            step.bounce = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin : datapath
    frame_nxt  = frame_r;
    acc_nxt    = acc_r;
    bounce_nxt = bounce_r;
    mode_nxt   = mode_r;
    speed_nxt  = speed_r;
    advanced   = 1'b0;
    if (accept) begin
      unique case (cmd_t'(command))
        CMD_TICK: begin
          if (state_r == ST_PLAYING) begin
            acc_nxt = acc_sat;
            if (reach) begin
              advanced   = 1'b1;
              acc_nxt    = '0;
              frame_nxt  = step.stop ? 6'd0 : step.frame;
              bounce_nxt = step.bounce;
            end
          end
        end
        CMD_START: begin
          if (state_r == ST_STOPPED) begin
            mode_nxt  = play_mode;
            speed_nxt = play_speed;
            acc_nxt   = '0;
            case (play_mode) inside
              MODE_REV, MODE_REV_DIE, MODE_REV_LOOP: frame_nxt = last_r;
              MODE_PASS, MODE_PASS_DIE, MODE_LOOP, MODE_PINGPONG: begin
                frame_nxt  = 6'd0;
                bounce_nxt = 1'b0;
              end
              default: ;
            endcase
          end
        end
        CMD_STOP: begin
          if (state_r == ST_PLAYING || state_r == ST_WAITING) begin
            frame_nxt = 6'd0;
            acc_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin : next_state
    state_nxt = state_r;
    if (accept) begin
      unique case (cmd_t'(command))
        CMD_TICK: begin
          if (state_r == ST_PLAYING && reach) begin
            if (step.stop) state_nxt = ST_STOPPED;
            else if (step.die) state_nxt = ST_DEAD;
          end
        end
        CMD_START: begin
          if (state_r == ST_STOPPED) state_nxt = ST_PLAYING;
        end
        CMD_STOP: begin
          if (state_r == ST_PLAYING || state_r == ST_WAITING) state_nxt = ST_STOPPED;
        end
        CMD_PAUSE: begin
          if (state_r == ST_PLAYING) state_nxt = ST_WAITING;
          else if (state_r == ST_WAITING) state_nxt = ST_PLAYING;
        end
        default: ;
      endcase
    end
  end

  always_comb begin : outputs
    result.frame_index    = frame_nxt;
    result.anim_state     = state_nxt;
    result.frame_advanced = advanced;
    dur_req.wr_en         = accept && (cmd_t'(command) == CMD_WRITE_DUR);
    dur_req.wr_slot       = frame_slot;
    dur_req.wr_data       = duration_us;
    // fetch the duration of the frame the next item will see
    dur_req.rd_frame      = rst_n ? frame_nxt : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_STOPPED;
      frame_r  <= '0;
      acc_r    <= '0;
      mode_r   <= MODE_PASS;
      speed_r  <= SPEED_ONE;
      bounce_r <= 1'b0;
      last_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      frame_r  <= frame_nxt;
      acc_r    <= acc_nxt;
      mode_r   <= mode_nxt;
      speed_r  <= speed_nxt;
      bounce_r <= bounce_nxt;
      if (cfg_wr_en) last_r <= cfg_wr_data;
    end
  end

endmodule

// ===== hdl/sfs_out_buf.sv =====
module sfs_out_buf
  import sfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t din,
  output logic    has_space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head_r
);

  logic [1:0] count_r, count_nxt;
  result_t    tail_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign has_space = (count_r != 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count_r == 2'd0 || (count_r == 2'd1 && pop))) begin
      head_r <= din;
    end else if (pop && count_r == 2'd2) begin
      head_r <= tail_r;
    end
    if (push && count_r == 2'd1 && !pop) begin
      tail_r <= din;
    end
  end

endmodule

// ===== hdl/sprite_frame_sequencer.sv =====
// channel  | ports               | contents
// ---------+---------------------+-----------------------------------------------
// input    | in_tvalid/tready    | tuser: command; tdata: tick, start and table data
// result   | out_tvalid/tready   | tdata: frame, state, advance flag
// config   | cfg_wr_en/wr_data   | last_frame
//
// one item per cycle while in_tready is high: state is updated in the cycle of the
// input transfer, and the result is registered into a two-entry output buffer
// the duration table read is issued for the frame the next item will use, so
// the registered memory read never stalls the input
// in_tready drops only while two results wait or reset is held; reset is
// synchronous, active low, and the duration table has no clearing pass
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // elapsed_us, play_mode, play_speed, frame_slot, duration_us
  input  logic [2:0]  in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // frame_index, anim_state, frame_advanced
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  logic     accept;
  logic     has_space;
  dur_req_t dur_req;
  logic [23:0] dur_rd_data;
  result_t  result;
  result_t  head;

  assign in_tready = rst_n && has_space;
  assign accept    = in_tvalid && in_tready;

  sfs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_tuser),
    .elapsed_us  (in_tdata[19:0]),
    .play_mode   (in_tdata[22:20]),
    .play_speed  (in_tdata[38:23]),
    .frame_slot  (in_tdata[44:39]),
    .duration_us (in_tdata[68:45]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .dur_rd_data (dur_rd_data),
    .dur_req     (dur_req),
    .result      (result)
  );

  sfs_dur_mem #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dur_mem (
    .clk       (clk),
    .req       (dur_req),
    .rd_data_r (dur_rd_data)
  );

  sfs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (result),
    .has_space (has_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head_r    (head)
  );

  assign out_tdata = {7'd0, head.frame_advanced, head.anim_state, head.frame_index};

endmodule

// ===== hdl/sfs_checker.sv =====
module sfs_checker
  import sfs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic out_xfer;
  logic seen_dead_r;

  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_dead_r <= 1'b0;
    end else if (out_xfer && out_tdata[7:6] == ST_DEAD) begin
      seen_dead_r <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // dead is terminal until reset
  a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_dead_r |-> out_tdata[7:6] == ST_DEAD)
    else $error("left dead state");

  // stopped always shows frame 0
  a_stopped_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tdata[7:6] == ST_STOPPED |-> out_tdata[5:0] == 6'd0)
    else $error("stopped with nonzero frame");

  // an advance only comes from playing
  a_adv_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tdata[8] |-> out_tdata[7:6] != ST_WAITING)
    else $error("advance reported while waiting");

  // input only backs up behind pending results
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
